// ===== src/tbrl_pkg.sv =====
// ----------------------------------------------------------------------------
// tbrl_pkg
// Shared constants and types for the token bucket rate limiter.
// ----------------------------------------------------------------------------
package tbrl_pkg;

    localparam int          TOKEN_WIDTH_DEF = 16;
    localparam int          TIME_WIDTH_DEF  = 32;
    localparam int          COUNT_W         = 32;
    localparam int unsigned MS_PER_SECOND   = 1000;
    // bits needed to hold MS_PER_SECOND
    localparam int          MS_BITS         = 10;
    localparam int unsigned RATE_RESET      = 10;
    localparam int unsigned CAPACITY_RESET  = 16;

    typedef enum logic [0:0] {
        CFG_REFILL_RATE     = 1'b0,
        CFG_BUCKET_CAPACITY = 1'b1
    } cfg_index_t;

endpackage

// ===== src/tbrl_elapsed.sv =====
// ----------------------------------------------------------------------------
// tbrl_elapsed
// Input stage: elapsed time since last refill, refill time update, clamp.
// ----------------------------------------------------------------------------
module tbrl_elapsed #(
    parameter int TOKEN_WIDTH = tbrl_pkg::TOKEN_WIDTH_DEF,
    parameter int TIME_WIDTH  = tbrl_pkg::TIME_WIDTH_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       ready,
    input  logic [TIME_WIDTH-1:0]                      now_ms,
    output logic                                       out_valid,
    input  logic                                       down_ready,
    output logic [TOKEN_WIDTH+tbrl_pkg::MS_BITS-1:0]   elapsed_clamped
);
    import tbrl_pkg::*;

    localparam int CLAMP_W = TOKEN_WIDTH + MS_BITS;
    localparam int EXT_W   = (TIME_WIDTH > CLAMP_W) ? TIME_WIDTH : CLAMP_W;
    // beyond this many ms the bucket refills completely at any nonzero rate
    localparam logic [EXT_W-1:0] LIMIT = EXT_W'(MS_PER_SECOND) << TOKEN_WIDTH;

    logic                  valid_reg;
    logic                  accept;
    logic [TIME_WIDTH-1:0] last_refill_reg;
    logic [TIME_WIDTH-1:0] last_refill_next;
    logic [TIME_WIDTH-1:0] elapsed;
    logic [EXT_W-1:0]      elapsed_ext;
    logic                  refill_due;
    logic [CLAMP_W-1:0]    clamp_reg;
    logic [CLAMP_W-1:0]    clamp_next;

    assign ready  = !valid_reg || down_ready;
    assign accept = in_valid && ready;

    always_comb
    begin
        elapsed          = now_ms - last_refill_reg;
        refill_due       = elapsed >= TIME_WIDTH'(MS_PER_SECOND);
        elapsed_ext      = EXT_W'(elapsed);
        clamp_next       = (elapsed_ext >= LIMIT) ? LIMIT[CLAMP_W-1:0]
                                                  : elapsed_ext[CLAMP_W-1:0];
        last_refill_next = (accept && refill_due) ? now_ms : last_refill_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= 1'b0;
            last_refill_reg <= '0;
        end
        else
        begin
            if (ready)
            begin
                valid_reg <= in_valid;
            end
            last_refill_reg <= last_refill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            clamp_reg <= clamp_next;
        end
    end

    assign out_valid       = valid_reg;
    assign elapsed_clamped = clamp_reg;

endmodule

// ===== src/tbrl_seconds.sv =====
// ----------------------------------------------------------------------------
// tbrl_seconds
// Whole seconds from clamped milliseconds by reciprocal multiplication.
// ----------------------------------------------------------------------------
module tbrl_seconds #(
    parameter int TOKEN_WIDTH = tbrl_pkg::TOKEN_WIDTH_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       ready,
    input  logic [TOKEN_WIDTH+tbrl_pkg::MS_BITS-1:0]   elapsed_clamped,
    output logic                                       out_valid,
    input  logic                                       down_ready,
    output logic [TOKEN_WIDTH:0]                       secs
);
    import tbrl_pkg::*;

    localparam int CLAMP_W = TOKEN_WIDTH + MS_BITS;
    localparam int SHIFT   = CLAMP_W + MS_BITS;
    localparam int RECIP_W = CLAMP_W + 1;
    localparam int PROD_W  = CLAMP_W + RECIP_W;
    // ceiling reciprocal; exact quotient for every CLAMP_W-bit numerator
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) / 64'(MS_PER_SECOND)) + 64'd1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    logic                 valid_reg;
    logic                 accept;
    logic [PROD_W-1:0]    product;
    logic [TOKEN_WIDTH:0] secs_reg;

    assign ready  = !valid_reg || down_ready;
    assign accept = in_valid && ready;

    assign product = PROD_W'(elapsed_clamped) * PROD_W'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            secs_reg <= product[SHIFT +: TOKEN_WIDTH+1];
        end
    end

    assign out_valid = valid_reg;
    assign secs      = secs_reg;

endmodule

// ===== src/tbrl_refill.sv =====
// ----------------------------------------------------------------------------
// tbrl_refill
// Tokens to add: seconds times refill rate, saturated to the token width.
// ----------------------------------------------------------------------------
module tbrl_refill #(
    parameter int TOKEN_WIDTH = tbrl_pkg::TOKEN_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   ready,
    input  logic [TOKEN_WIDTH:0]   secs,
    input  logic [TOKEN_WIDTH-1:0] refill_rate,
    output logic                   out_valid,
    input  logic                   down_ready,
    output logic [TOKEN_WIDTH-1:0] add_tokens
);
    localparam int PROD_W = 2 * TOKEN_WIDTH + 1;

    logic                   valid_reg;
    logic                   accept;
    logic [PROD_W-1:0]      product;
    logic                   overflow;
    logic [TOKEN_WIDTH-1:0] add_reg;
    logic [TOKEN_WIDTH-1:0] add_next;

    assign ready  = !valid_reg || down_ready;
    assign accept = in_valid && ready;

    always_comb
    begin
        product  = PROD_W'(secs) * PROD_W'(refill_rate);
        overflow = |product[PROD_W-1:TOKEN_WIDTH];
        // all ones is never below the room left in the bucket
        add_next = overflow ? '1 : product[TOKEN_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            add_reg <= add_next;
        end
    end

    assign out_valid  = valid_reg;
    assign add_tokens = add_reg;

endmodule

// ===== src/tbrl_bucket.sv =====
// ----------------------------------------------------------------------------
// tbrl_bucket
// Token count, capacity, spend decision, counters and result register.
// ----------------------------------------------------------------------------
module tbrl_bucket #(
    parameter int TOKEN_WIDTH = tbrl_pkg::TOKEN_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            ready,
    input  logic [TOKEN_WIDTH-1:0]          add_tokens,
    input  logic                            cap_we,
    input  logic [TOKEN_WIDTH-1:0]          cap_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            allowed,
    output logic [TOKEN_WIDTH-1:0]          tokens_left,
    output logic [tbrl_pkg::COUNT_W-1:0]    allowed_count,
    output logic [tbrl_pkg::COUNT_W-1:0]    blocked_count
);
    import tbrl_pkg::*;

    logic                   valid_reg;
    logic                   accept;
    logic [TOKEN_WIDTH-1:0] cap_reg;
    logic [TOKEN_WIDTH-1:0] token_reg;
    logic [TOKEN_WIDTH-1:0] token_next;
    logic [TOKEN_WIDTH-1:0] room;
    logic [TOKEN_WIDTH-1:0] filled;
    logic                   pass;
    logic                   allowed_reg;
    logic [TOKEN_WIDTH-1:0] tokens_left_reg;
    logic [COUNT_W-1:0]     allowed_count_reg;
    logic [COUNT_W-1:0]     blocked_count_reg;

    assign ready  = !valid_reg || !out_stall;
    assign accept = in_valid && ready;

    // token count never exceeds capacity, so room cannot underflow
    always_comb
    begin
        room       = cap_reg - token_reg;
        filled     = (add_tokens >= room) ? cap_reg : token_reg + add_tokens;
        pass       = filled != '0;
        token_next = pass ? filled - 1'b1 : filled;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg         <= 1'b0;
            cap_reg           <= TOKEN_WIDTH'(CAPACITY_RESET);
            token_reg         <= TOKEN_WIDTH'(CAPACITY_RESET);
            allowed_count_reg <= '0;
            blocked_count_reg <= '0;
        end
        else
        begin
            if (ready)
            begin
                valid_reg <= in_valid;
            end
            if (accept)
            begin
                token_reg <= token_next;
                if (pass)
                begin
                    allowed_count_reg <= allowed_count_reg + 1'b1;
                end
                else
                begin
                    blocked_count_reg <= blocked_count_reg + 1'b1;
                end
            end
            else if (cap_we)
            begin
                cap_reg <= cap_data;
                if (token_reg > cap_data)
                begin
                    token_reg <= cap_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            allowed_reg     <= pass;
            tokens_left_reg <= token_next;
        end
    end

    assign out_valid     = valid_reg;
    assign allowed       = allowed_reg;
    assign tokens_left   = tokens_left_reg;
    assign allowed_count = allowed_count_reg;
    assign blocked_count = blocked_count_reg;

endmodule

// ===== src/token_bucket_rate_limiter.sv =====
// ----------------------------------------------------------------------------
// token_bucket_rate_limiter
// Token bucket policer on a stream of timestamped message arrivals.
// ----------------------------------------------------------------------------
// Input channel: one beat per message, carrying now_ms (wrapping ms clock).
// Output channel: one beat per message with the pass/block verdict, the
// tokens left and the wrapping allowed and blocked totals.
// Both channels: a beat moves on a rising edge with valid high, stall low.
// Four-stage pipeline: elapsed time, seconds (reciprocal multiply), refill
// amount (rate multiply), then bucket update into the result register.
// One beat per cycle is sustained while out_stall stays low, set by the
// token update loop in the last stage.
// Result stall backs up stage by stage; in_stall rises only once every
// stage holds a beat.
// Reset: bucket full at the default capacity (16), refill rate 10, refill
// time and both totals zero, pipeline empty.
// The user must make register writes (cfg_we, cfg_index, cfg_data) only while
// idle; the block does not enforce it. Capacity writes clamp the token count.
// ----------------------------------------------------------------------------
module token_bucket_rate_limiter #(
    parameter int TOKEN_WIDTH = tbrl_pkg::TOKEN_WIDTH_DEF,
    parameter int TIME_WIDTH  = tbrl_pkg::TIME_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [TIME_WIDTH-1:0]           now_ms,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            allowed,
    output logic [TOKEN_WIDTH-1:0]          tokens_left,
    output logic [tbrl_pkg::COUNT_W-1:0]    allowed_count,
    output logic [tbrl_pkg::COUNT_W-1:0]    blocked_count,
    input  logic                            cfg_we,
    input  tbrl_pkg::cfg_index_t            cfg_index,
    input  logic [TOKEN_WIDTH-1:0]          cfg_data
);
    import tbrl_pkg::*;

    localparam int CLAMP_W = TOKEN_WIDTH + MS_BITS;

    logic                   ready_el;
    logic                   valid_el;
    logic [CLAMP_W-1:0]     elapsed_clamped;
    logic                   ready_sec;
    logic                   valid_sec;
    logic [TOKEN_WIDTH:0]   secs;
    logic                   ready_ref;
    logic                   valid_ref;
    logic [TOKEN_WIDTH-1:0] add_tokens;
    logic                   ready_bkt;
    logic [TOKEN_WIDTH-1:0] rate_reg;
    logic                   rate_we;
    logic                   cap_we;

    always_comb
    begin
        rate_we = 1'b0;
        cap_we  = 1'b0;
        unique case (cfg_index)
            CFG_REFILL_RATE:     rate_we = cfg_we;
            CFG_BUCKET_CAPACITY: cap_we  = cfg_we;
            default:             rate_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= TOKEN_WIDTH'(RATE_RESET);
        end
        else if (rate_we)
        begin
            rate_reg <= cfg_data;
        end
    end

    assign in_stall = !ready_el;

    tbrl_elapsed #(
        .TOKEN_WIDTH (TOKEN_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_elapsed (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .ready           (ready_el),
        .now_ms          (now_ms),
        .out_valid       (valid_el),
        .down_ready      (ready_sec),
        .elapsed_clamped (elapsed_clamped)
    );

    tbrl_seconds #(
        .TOKEN_WIDTH (TOKEN_WIDTH)
    ) u_seconds (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (valid_el),
        .ready           (ready_sec),
        .elapsed_clamped (elapsed_clamped),
        .out_valid       (valid_sec),
        .down_ready      (ready_ref),
        .secs            (secs)
    );

    tbrl_refill #(
        .TOKEN_WIDTH (TOKEN_WIDTH)
    ) u_refill (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (valid_sec),
        .ready       (ready_ref),
        .secs        (secs),
        .refill_rate (rate_reg),
        .out_valid   (valid_ref),
        .down_ready  (ready_bkt),
        .add_tokens  (add_tokens)
    );

    tbrl_bucket #(
        .TOKEN_WIDTH (TOKEN_WIDTH)
    ) u_bucket (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (valid_ref),
        .ready         (ready_bkt),
        .add_tokens    (add_tokens),
        .cap_we        (cap_we),
        .cap_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .allowed       (allowed),
        .tokens_left   (tokens_left),
        .allowed_count (allowed_count),
        .blocked_count (blocked_count)
    );

endmodule
